### hw/rtl/pwbd_pkg.sv
// shared types, constants and register indexes of the pulse width bit decoder
package pwbd_pkg;

  // default width of the captured durations
  localparam int DUR_BITS_DEF = 15;

  // configuration port shape
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOWED_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HALF_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HALF_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT      = 3'd6;

  // register reset values
  localparam logic [15:0] WINDOW_LOW_RST      = 16'd600;
  localparam logic [15:0] WINDOW_HIGH_RST     = 16'd1100;
  localparam logic [14:0] FIRST_HALF_MIN_RST  = 15'd500;
  localparam logic [14:0] SECOND_HALF_MIN_RST = 15'd200;

  // depth of the queue between classifier and frame assembler
  localparam int QUEUE_DEPTH = 2;

  // configuration seen by both halves
  typedef struct packed {
    logic        windowed_mode;
    logic        msb_first;
    logic [15:0] window_low;
    logic [15:0] window_high;
    logic [14:0] first_half_min;
    logic [14:0] second_half_min;
    logic [15:0] byte_limit;
  } pwbd_cfg_t;

  // classified pulse item
  typedef struct packed {
    logic first_item;
    logic last_item;
    logic pair_ok;
    logic bit_val;
  } pwbd_item_t;

endpackage

### hw/rtl/pwbd_front.sv
// front end: accepts pulse beats, forms the pair and classifies it
module pwbd_front
  import pwbd_pkg::*;
#(
  parameter int DURATION_BITS = DUR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pwbd_cfg_t                cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DURATION_BITS-1:0] in_high_duration,
  input  logic [DURATION_BITS-1:0] in_low_duration,
  input  logic                     in_first_item,
  input  logic                     in_last_item,
  input  logic                     push_ready,
  output logic                     push_valid,
  output pwbd_item_t               push_item
);

  localparam int SUM_W = DURATION_BITS + 1;
  localparam int WIN_W = (SUM_W > 16) ? SUM_W : 16;
  localparam int LVL_W = (DURATION_BITS > 15) ? DURATION_BITS : 15;

  logic [DURATION_BITS-1:0] pending_half_r, pending_half_nxt;
  logic [SUM_W-1:0]         pair_sum;
  logic                     win_ok, lvl_ok, pair_ok, accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // pair check: window on the sum, or a minimum on each half
  always_comb begin
    pair_sum = SUM_W'(pending_half_r) + SUM_W'(in_high_duration);
    win_ok   = (WIN_W'(pair_sum) > WIN_W'(cfg.window_low)) &&
               (WIN_W'(pair_sum) < WIN_W'(cfg.window_high));
    lvl_ok   = (LVL_W'(pending_half_r) > LVL_W'(cfg.first_half_min)) &&
               (LVL_W'(in_high_duration) > LVL_W'(cfg.second_half_min));
    pair_ok  = cfg.windowed_mode ? win_ok : lvl_ok;
  end

  // classified beat towards the queue
  always_comb begin
    push_item.first_item = in_first_item;
    push_item.last_item  = in_last_item;
    push_item.pair_ok    = pair_ok;
    push_item.bit_val    = pending_half_r > in_high_duration;
  end

  // low half waits to become the first half of the next pair
  always_comb begin
    pending_half_nxt = pending_half_r;
    if (accept && (in_first_item || pair_ok)) begin
      pending_half_nxt = in_low_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_half_r <= '0;
    end else begin
      pending_half_r <= pending_half_nxt;
    end
  end

endmodule

### hw/rtl/pwbd_queue.sv
// short queue of classified items between front and back end
module pwbd_queue
  import pwbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  pwbd_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output pwbd_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  pwbd_item_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/pwbd_back.sv
// back end: packs bits into bytes, tracks the frame and holds the result beat
module pwbd_back
  import pwbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pwbd_cfg_t  cfg,
  input  logic       item_valid,
  output logic       item_ready,
  input  pwbd_item_t item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_bits_in_byte,
  output logic       out_frame_end,
  output logic       out_stopped_on_invalid
);

  logic [7:0]  shift_r, shift_nxt, sb_new;
  logic [2:0]  cnt_r, cnt_nxt, cnt_new, pad_sh;
  logic [15:0] bytes_r, bytes_nxt;
  logic        active_r, active_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic [3:0]  obits_r, obits_nxt;
  logic        oend_r, oend_nxt, oinv_r, oinv_nxt;
  logic        take, have, ended, invalid, byte_full;
  logic [3:0]  part_bits;

  assign item_ready = !ovalid_r || out_ready;
  assign take       = item_valid && item_ready;

  assign out_valid              = ovalid_r;
  assign out_data_byte          = obyte_r;
  assign out_bits_in_byte       = obits_r;
  assign out_frame_end          = oend_r;
  assign out_stopped_on_invalid = oinv_r;

  // frame assembly for one classified item
  always_comb begin
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    bytes_nxt  = bytes_r;
    active_nxt = active_r;
    have       = 1'b0;
    ended      = 1'b0;
    invalid    = 1'b0;
    byte_full  = 1'b0;
    obyte_nxt  = obyte_r;
    obits_nxt  = obits_r;
    sb_new     = cfg.msb_first ? {shift_r[6:0], item.bit_val}
                               : (shift_r | (8'(item.bit_val) << cnt_r));
    cnt_new    = cnt_r + 1'b1;
    part_bits  = 4'd0;
    pad_sh     = 3'd0;

    if (take) begin
      if (item.first_item) begin
        // new frame, drops any unfinished one
        shift_nxt  = '0;
        cnt_nxt    = '0;
        bytes_nxt  = '0;
        active_nxt = 1'b1;
        ended      = item.last_item;
      end else if (active_r) begin
        if (item.pair_ok) begin
          ended = item.last_item;
          if (cnt_r == 3'd7) begin
            byte_full = 1'b1;
            have      = 1'b1;
            obyte_nxt = sb_new;
            obits_nxt = 4'd8;
            shift_nxt = '0;
            cnt_nxt   = '0;
            if (bytes_r != 16'hFFFF) begin
              bytes_nxt = bytes_r + 1'b1;
            end
          end else begin
            shift_nxt = sb_new;
            cnt_nxt   = cnt_new;
          end
        end else begin
          ended   = 1'b1;
          invalid = 1'b1;
        end
      end

      // byte limit stops the frame
      if ((item.first_item || active_r) && !ended && cfg.byte_limit != '0 &&
          bytes_nxt >= cfg.byte_limit - 1'b1) begin
        ended = 1'b1;
      end

      // flush of the partial byte at frame end
      if (ended) begin
        if (!byte_full) begin
          have      = 1'b1;
          part_bits = {1'b0, cnt_nxt};
          pad_sh    = 3'(4'd8 - part_bits);
          obits_nxt = part_bits;
          obyte_nxt = (cfg.msb_first && cnt_nxt != '0) ? (shift_nxt << pad_sh)
                                                        : shift_nxt;
        end
        active_nxt = 1'b0;
        shift_nxt  = '0;
        cnt_nxt    = '0;
      end
    end

    oend_nxt   = have ? ended   : oend_r;
    oinv_nxt   = have ? invalid : oinv_r;
    ovalid_nxt = have ? 1'b1 : (ovalid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      cnt_r    <= '0;
      bytes_r  <= '0;
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      shift_r  <= shift_nxt;
      cnt_r    <= cnt_nxt;
      bytes_r  <= bytes_nxt;
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    obits_r <= obits_nxt;
    oend_r  <= oend_nxt;
    oinv_r  <= oinv_nxt;
  end

endmodule

### hw/rtl/pulse_width_bit_decoder_unit.sv
// top level of the pulse width bit decoder: register file, front, queue, back
//
// channel | direction | fields
// in_*    | in        | high_duration, low_duration, first_item, last_item
// out_*   | out       | data_byte, bits_in_byte, frame_end, stopped_on_invalid
// cfg_*   | in        | index, data (one register per beat)
//
// one beat per cycle sustained while the output is not stalled; a beat passes through
// front classify, queue slot, back assembly into the output register, in that order
// the frame state lives in the back end, so the byte count and bit count
// close their loop there
// reset is synchronous and active low, configuration registers return to their defaults
// a stalled output fills the two-entry queue, then in_ready drops
module pulse_width_bit_decoder_unit
  import pwbd_pkg::*;
#(
  parameter int DURATION_BITS = DUR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DURATION_BITS-1:0] in_high_duration,
  input  logic [DURATION_BITS-1:0] in_low_duration,
  input  logic                     in_first_item,
  input  logic                     in_last_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_data_byte,
  output logic [3:0]               out_bits_in_byte,
  output logic                     out_frame_end,
  output logic                     out_stopped_on_invalid
);

  pwbd_cfg_t  cfg_r, cfg_nxt;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  pwbd_item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOWED_MODE:   cfg_nxt.windowed_mode   = cfg_data[0];
        REG_MSB_FIRST:       cfg_nxt.msb_first       = cfg_data[0];
        REG_WINDOW_LOW:      cfg_nxt.window_low      = cfg_data;
        REG_WINDOW_HIGH:     cfg_nxt.window_high     = cfg_data;
        REG_FIRST_HALF_MIN:  cfg_nxt.first_half_min  = cfg_data[14:0];
        REG_SECOND_HALF_MIN: cfg_nxt.second_half_min = cfg_data[14:0];
        REG_BYTE_LIMIT:      cfg_nxt.byte_limit      = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.windowed_mode   <= 1'b1;
      cfg_r.msb_first       <= 1'b1;
      cfg_r.window_low      <= WINDOW_LOW_RST;
      cfg_r.window_high     <= WINDOW_HIGH_RST;
      cfg_r.first_half_min  <= FIRST_HALF_MIN_RST;
      cfg_r.second_half_min <= SECOND_HALF_MIN_RST;
      cfg_r.byte_limit      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pair classification
  pwbd_front #(
    .DURATION_BITS(DURATION_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_high_duration (in_high_duration),
    .in_low_duration  (in_low_duration),
    .in_first_item    (in_first_item),
    .in_last_item     (in_last_item),
    .push_ready       (push_ready),
    .push_valid       (push_valid),
    .push_item        (push_item)
  );

  // decoupling queue
  pwbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // frame assembly and result register
  pwbd_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .item_valid             (pop_valid),
    .item_ready             (pop_ready),
    .item                   (pop_item),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_data_byte          (out_data_byte),
    .out_bits_in_byte       (out_bits_in_byte),
    .out_frame_end          (out_frame_end),
    .out_stopped_on_invalid (out_stopped_on_invalid)
  );

endmodule

### hw/rtl/pwbd_checker.sv
// port level checks on the result channel of the decoder, bound to the top level
module pwbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic [3:0] out_bits_in_byte,
  input logic       out_frame_end,
  input logic       out_stopped_on_invalid
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
    $stable(out_bits_in_byte) && $stable(out_frame_end))
    else $error("result beat changed under stall");

  // never more than a byte of bits
  a_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bits_in_byte <= 4'd8)
    else $error("bit count above eight");

  // invalid pair always closes the frame
  a_inv_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped_on_invalid |-> out_frame_end)
    else $error("invalid stop without frame end");

  // mid-frame results carry full bytes only
  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_bits_in_byte == 4'd8)
    else $error("partial byte before frame end");

  // nothing offered straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pulse_width_bit_decoder_unit pwbd_checker u_pwbd_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_data_byte          (out_data_byte),
  .out_bits_in_byte       (out_bits_in_byte),
  .out_frame_end          (out_frame_end),
  .out_stopped_on_invalid (out_stopped_on_invalid)
);

### tb/pulse_width_bit_decoder_unit_tb.sv
// testbench of the pulse width bit decoder: pulse stimulus, byte prediction and checking
`timescale 1ns / 1ps

module pulse_width_bit_decoder_unit_tb
  import pwbd_pkg::*;
;

  localparam int DUR_W         = DUR_BITS_DEF;
  localparam int DUR_MAX       = (1 << DUR_W) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int PHASE_ITEMS   = 210;

  // one decoded beat on the result channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] bits_in_byte;
    logic       frame_end;
    logic       stopped_on_invalid;
  } decoded_beat_t;

  // predicts decoded bytes from accepted pulses and checks the result beats
  class pulse_frame_scoreboard;
    pwbd_cfg_t          regs;
    logic [DUR_W-1:0]   pending_half;
    logic [7:0]         shift_byte;
    logic [3:0]         bits_held;
    logic [15:0]        full_bytes;
    bit                 frame_on;
    decoded_beat_t      expected_bytes[$];
    int                 fails;

    function new();
      regs.windowed_mode   = 1'b1;
      regs.msb_first       = 1'b1;
      regs.window_low      = WINDOW_LOW_RST;
      regs.window_high     = WINDOW_HIGH_RST;
      regs.first_half_min  = FIRST_HALF_MIN_RST;
      regs.second_half_min = SECOND_HALF_MIN_RST;
      regs.byte_limit      = '0;
      pending_half = '0;
      shift_byte   = '0;
      bits_held    = '0;
      full_bytes   = '0;
      frame_on     = 1'b0;
      fails        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOWED_MODE:   regs.windowed_mode   = data[0];
        REG_MSB_FIRST:       regs.msb_first       = data[0];
        REG_WINDOW_LOW:      regs.window_low      = data;
        REG_WINDOW_HIGH:     regs.window_high     = data;
        REG_FIRST_HALF_MIN:  regs.first_half_min  = data[14:0];
        REG_SECOND_HALF_MIN: regs.second_half_min = data[14:0];
        REG_BYTE_LIMIT:      regs.byte_limit      = data;
        default: ;
      endcase
    endfunction

    // decode one accepted pulse beat into at most one expected result
    function void note_pulse(logic [DUR_W-1:0] high_dur, logic [DUR_W-1:0] low_dur,
                             logic first, logic last);
      logic          have;
      logic          ended;
      logic          bad;
      logic          good;
      logic          bit_v;
      logic [16:0]   pair_sum;
      decoded_beat_t r;
      have = 1'b0;
      ended = 1'b0;
      bad = 1'b0;
      r = '0;
      if (first) begin
        pending_half = low_dur;
        shift_byte   = '0;
        bits_held    = '0;
        full_bytes   = '0;
        frame_on     = 1'b1;
        ended        = last;
      end else begin
        if (!frame_on) return;
        // timing check of the pair: previous low half, then this high half
        if (regs.windowed_mode) begin
          pair_sum = {2'b00, pending_half} + {2'b00, high_dur};
          good = (pair_sum > {1'b0, regs.window_low}) && (pair_sum < {1'b0, regs.window_high});
        end else begin
          good = (pending_half > regs.first_half_min) && (high_dur > regs.second_half_min);
        end
        if (good) begin
          bit_v = pending_half > high_dur;
          if (regs.msb_first) shift_byte = {shift_byte[6:0], bit_v};
          else shift_byte[bits_held[2:0]] = bit_v;
          bits_held = bits_held + 4'd1;
          // full byte leaves at once
          if (bits_held == 4'd8) begin
            have = 1'b1;
            r.data_byte = shift_byte;
            r.bits_in_byte = 4'd8;
            shift_byte = '0;
            bits_held = '0;
            if (full_bytes != 16'hFFFF) full_bytes = full_bytes + 16'd1;
          end
          pending_half = low_dur;
          ended = last;
        end else begin
          ended = 1'b1;
          bad = 1'b1;
        end
      end
      if (!ended && regs.byte_limit != 16'd0 && full_bytes >= regs.byte_limit - 16'd1)
        ended = 1'b1;
      // frame end flushes the partial byte, or an empty beat
      if (ended) begin
        if (!have) begin
          have = 1'b1;
          r.bits_in_byte = bits_held;
          if (bits_held != 4'd0 && regs.msb_first) r.data_byte = shift_byte << (8 - bits_held);
          else r.data_byte = shift_byte;
        end
        frame_on = 1'b0;
        shift_byte = '0;
        bits_held = '0;
      end
      if (have) begin
        r.frame_end = ended;
        r.stopped_on_invalid = bad;
        expected_bytes.insert(expected_bytes.size(), r);
      end
    endfunction

    function void check_beat(decoded_beat_t got);
      decoded_beat_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result beat: data_byte %0h bits_in_byte %0d", got.data_byte,
               got.bits_in_byte);
        fails++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        fails++;
      end
      if (got.bits_in_byte !== want.bits_in_byte) begin
        $error("bits_in_byte: expected %0d, got %0d", want.bits_in_byte, got.bits_in_byte);
        fails++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
        fails++;
      end
      if (got.stopped_on_invalid !== want.stopped_on_invalid) begin
        $error("stopped_on_invalid: expected %0b, got %0b", want.stopped_on_invalid,
               got.stopped_on_invalid);
        fails++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DUR_W-1:0]      in_high_duration = '0;
  logic [DUR_W-1:0]      in_low_duration = '0;
  logic                  in_first_item = 1'b0;
  logic                  in_last_item = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_data_byte;
  logic [3:0]            out_bits_in_byte;
  logic                  out_frame_end;
  logic                  out_stopped_on_invalid;

  pulse_frame_scoreboard sb;
  bit                    calm = 1'b0;
  int                    items_sent = 0;
  int                    cycles = 0;

  pulse_width_bit_decoder_unit dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_high_duration       (in_high_duration),
    .in_low_duration        (in_low_duration),
    .in_first_item          (in_first_item),
    .in_last_item           (in_last_item),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_data_byte          (out_data_byte),
    .out_bits_in_byte       (out_bits_in_byte),
    .out_frame_end          (out_frame_end),
    .out_stopped_on_invalid (out_stopped_on_invalid)
  );

  // clock
  always #10 clk = ~clk;

  // receiver stalls at random outside the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 38);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat({out_data_byte, out_bits_in_byte, out_frame_end, out_stopped_on_invalid});
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one pulse beat, with random idle cycles ahead of it
  task automatic send_pulse(logic [DUR_W-1:0] high_dur, logic [DUR_W-1:0] low_dur,
                            logic first, logic last);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_high_duration <= high_dur;
    in_low_duration <= low_dur;
    in_first_item <= first;
    in_last_item <= last;
    do @(posedge clk); while (!in_ready);
    if (first || sb.frame_on) items_sent++;
    sb.note_pulse(high_dur, low_dur, first, last);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(pwbd_cfg_t s);
    write_reg(REG_WINDOWED_MODE, CFG_DATA_W'(s.windowed_mode));
    write_reg(REG_MSB_FIRST, CFG_DATA_W'(s.msb_first));
    write_reg(REG_WINDOW_LOW, s.window_low);
    write_reg(REG_WINDOW_HIGH, s.window_high);
    write_reg(REG_FIRST_HALF_MIN, CFG_DATA_W'(s.first_half_min));
    write_reg(REG_SECOND_HALF_MIN, CFG_DATA_W'(s.second_half_min));
    write_reg(REG_BYTE_LIMIT, s.byte_limit);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every expected byte is out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a low half from which a valid pair can still be formed
  function automatic logic [DUR_W-1:0] pick_low();
    int top;
    int bot;
    if (sb.regs.windowed_mode) begin
      top = int'(sb.regs.window_high) - 2;
      bot = int'(sb.regs.window_low) + 1 - DUR_MAX;
      if (top > DUR_MAX) top = DUR_MAX;
      if (bot < 0) bot = 0;
      if (bot > top) return DUR_W'($urandom_range(0, DUR_MAX));
      return DUR_W'($urandom_range(bot, top));
    end
    if (sb.regs.first_half_min == DUR_W'(DUR_MAX)) return DUR_W'($urandom_range(0, DUR_MAX));
    return DUR_W'($urandom_range(int'(sb.regs.first_half_min) + 1, DUR_MAX));
  endfunction

  // a high half that makes the pair with the given first half valid
  function automatic logic [DUR_W-1:0] pick_high(logic [DUR_W-1:0] first_half);
    int s_lo;
    int s_hi;
    if (sb.regs.windowed_mode) begin
      s_lo = int'(sb.regs.window_low) + 1;
      s_hi = int'(sb.regs.window_high) - 1;
      if (s_lo < int'(first_half)) s_lo = int'(first_half);
      if (s_hi > int'(first_half) + DUR_MAX) s_hi = int'(first_half) + DUR_MAX;
      if (s_lo > s_hi) return DUR_W'($urandom_range(0, DUR_MAX));
      return DUR_W'(int'($urandom_range(s_lo, s_hi)) - int'(first_half));
    end
    if (sb.regs.second_half_min == DUR_W'(DUR_MAX)) return DUR_W'($urandom_range(0, DUR_MAX));
    return DUR_W'($urandom_range(int'(sb.regs.second_half_min) + 1, DUR_MAX));
  endfunction

  // one frame: mostly timed pairs, some noise and restarts
  task automatic run_frame();
    int               len;
    int               r;
    int               i;
    logic [DUR_W-1:0] hi;
    logic [DUR_W-1:0] lo;
    logic [DUR_W-1:0] pend;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 12);
    lo = pick_low();
    send_pulse(DUR_W'($urandom_range(0, DUR_MAX)), lo, 1'b1, len == 0);
    pend = lo;
    for (i = 1; i <= len && sb.frame_on; i++) begin
      r = $urandom_range(0, 99);
      lo = (r >= 95) ? DUR_W'($urandom_range(0, DUR_MAX)) : pick_low();
      hi = (r < 5) ? DUR_W'($urandom_range(0, DUR_MAX)) : pick_high(pend);
      send_pulse(hi, lo, r >= 5 && r < 8, i == len);
      pend = lo;
    end
  endtask

  task automatic run_phase(pwbd_cfg_t s);
    int goal;
    drain_results();
    apply_setting(s);
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      // stray beat between frames, ignored by the block
      if ($urandom_range(0, 9) == 0)
        send_pulse(DUR_W'($urandom_range(0, DUR_MAX)), DUR_W'($urandom_range(0, DUR_MAX)),
                   1'b0, 1'($urandom_range(0, 1)));
      run_frame();
    end
  endtask

  initial begin
    pwbd_cfg_t s;
    sb = new();

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats on the reset settings
    // stray beat while idle
    send_pulse(15'd32767, 15'd32767, 1'b0, 1'b0);
    // first and last together
    send_pulse(15'd0, 15'd0, 1'b1, 1'b1);
    // eight timed pairs, the last beat closes a full byte
    send_pulse(15'd32767, 15'd600, 1'b1, 1'b0);
    send_pulse(15'd100, 15'd300, 1'b0, 1'b0);
    send_pulse(15'd700, 15'd0, 1'b0, 1'b0);
    send_pulse(15'd900, 15'd500, 1'b0, 1'b0);
    send_pulse(15'd200, 15'd450, 1'b0, 1'b0);
    send_pulse(15'd300, 15'd400, 1'b0, 1'b0);
    send_pulse(15'd400, 15'd650, 1'b0, 1'b0);
    send_pulse(15'd100, 15'd250, 1'b0, 1'b0);
    send_pulse(15'd500, 15'd0, 1'b0, 1'b1);
    // one bit, then a pair far outside the window
    send_pulse(15'd32767, 15'd700, 1'b1, 1'b0);
    send_pulse(15'd300, 15'd32767, 1'b0, 1'b0);
    send_pulse(15'd0, 15'd0, 1'b0, 1'b0);
    // invalid pair straight after the start: empty end
    send_pulse(15'd0, 15'd0, 1'b1, 1'b0);
    send_pulse(15'd0, 15'd0, 1'b0, 1'b0);
    // restart drops the unfinished frame
    send_pulse(15'd0, 15'd400, 1'b1, 1'b0);
    send_pulse(15'd500, 15'd400, 1'b0, 1'b0);
    send_pulse(15'd300, 15'd200, 1'b0, 1'b0);
    send_pulse(15'd0, 15'd800, 1'b1, 1'b0);
    send_pulse(15'd200, 15'd0, 1'b0, 1'b1);

    // windowed, msb first, default window
    s = '{1'b1, 1'b1, 16'd600, 16'd1100, 15'd500, 15'd200, 16'd0};
    run_phase(s);
    // windowed, lsb first, wide window, short frames
    s = '{1'b1, 1'b0, 16'd300, 16'd2000, 15'd500, 15'd200, 16'd3};
    run_phase(s);
    // level mode with no idling on either side
    calm = 1'b1;
    s = '{1'b0, 1'b1, 16'd600, 16'd1100, 15'd500, 15'd200, 16'd0};
    run_phase(s);
    calm = 1'b0;
    // level mode, zero minimums, frame ends at once
    s = '{1'b0, 1'b0, 16'd0, 16'd0, 15'd0, 15'd0, 16'd1};
    run_phase(s);
    // widest window, largest limit
    s = '{1'b1, 1'b1, 16'd0, 16'd65535, 15'd32767, 15'd32767, 16'd65535};
    run_phase(s);
    // level minimums at the top: no pair passes
    s = '{1'b0, 1'b1, 16'd65535, 16'd65535, 15'd32767, 15'd32767, 16'd2};
    run_phase(s);
    // empty window
    s = '{1'b1, 1'b0, 16'd65535, 16'd0, 15'd0, 15'd0, 16'd0};
    run_phase(s);
    // random settings
    s.windowed_mode   = 1'($urandom_range(0, 1));
    s.msb_first       = 1'($urandom_range(0, 1));
    s.window_low      = 16'($urandom_range(0, 2000));
    s.window_high     = s.window_low + 16'($urandom_range(0, 3000));
    s.first_half_min  = 15'($urandom_range(0, 4000));
    s.second_half_min = 15'($urandom_range(0, 4000));
    s.byte_limit      = 16'($urandom_range(0, 6));
    run_phase(s);

    drain_results();
    if (sb.fails == 0 && sb.expected_bytes.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pwbd_pkg.sv
hw/rtl/pwbd_front.sv
hw/rtl/pwbd_queue.sv
hw/rtl/pwbd_back.sv
hw/rtl/pulse_width_bit_decoder_unit.sv
hw/rtl/pwbd_checker.sv
tb/pulse_width_bit_decoder_unit_tb.sv
